FILE: design/prq_pkg.sv
// Shared types and codes for the priority run queue.
// Depends on nothing; used by prq_ctrl, prq_dp, the top level, the checker and the testbench.
package prq_pkg;

    localparam int FIELD_W = 6;  // width of slot and level fields on the ports
    localparam int CPU_W   = 4;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE   = 2'd0;
    localparam t_status ST_NONE   = 2'd1;
    localparam t_status ST_REJECT = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic    cap;
        logic    scan_init;
        logic    scan_sel;
        logic    walk_start;
        logic    walk_next;
        logic    ins_rd;
        logic    ins_wr;
        logic    unlink;
        logic    res_set;
        t_status res_code;
        logic    res_found;
        logic    out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_pick;
        logic ins_ok;
        logic mask_empty;
        logic eligible;
        logic next_null;
        logic out_free;
        logic bitmap_any;
        logic marks_any;
    } t_stat;

endpackage

FILE: design/priority_run_queue_with_affinity.sv
// Top level of the priority run queue with CPU affinity.
// Depends on prq_pkg, prq_ctrl and prq_dp.
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_ready  i_req_type i_thread_id i_priority_req
//                                          i_target_any i_target_cpu i_cpu_id i_min_prio
//  result    out        o_valid / i_ready  o_status o_picked_thread
//
// An accepted insert goes through decode, tail read, link write and the result stage;
// a rejected insert goes from decode straight to the result stage. A pick scans the
// nonempty levels within its limit, walking each list thread by thread through the
// thread link memory; one that finds none ends when no level is left to scan.
// Reset clears the level bitmap, queued marks and the output valid flag; the link
// memories need no clearing, as the bitmap tells which levels hold a list.
// One request is worked at a time; the next can be taken in the cycle after a result is staged.
// A finished result waits in the output register while the next request is taken, and
// the sequencer holds a further result until the output register frees.
module priority_run_queue_with_affinity import prq_pkg::*; #(
    parameter int NUM_LEVELS  = 64,
    parameter int MAX_THREADS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [FIELD_W-1:0] i_thread_id,
    input  logic [FIELD_W-1:0] i_priority_req,
    input  logic               i_target_any,
    input  logic [CPU_W-1:0]   i_target_cpu,
    input  logic [CPU_W-1:0]   i_cpu_id,
    input  logic [FIELD_W-1:0] i_min_prio,
    output logic               o_valid,
    input  logic               i_ready,
    output t_status            o_status,
    output logic [FIELD_W-1:0] o_picked_thread
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: walks each request through its steps
    prq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: lists, bitmap and result register
    prq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_thread_id     (i_thread_id),
        .i_priority_req  (i_priority_req),
        .i_target_any    (i_target_any),
        .i_target_cpu    (i_target_cpu),
        .i_cpu_id        (i_cpu_id),
        .i_min_prio      (i_min_prio),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_status        (o_status),
        .o_picked_thread (o_picked_thread),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

`ifndef SYNTHESIS
    // a bitmap bit is set exactly while some thread is queued
    a_bitmap_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.bitmap_any == stat.marks_any)
        else $error("level bitmap disagrees with queued marks");

    // an accepted request closes the input until its result is staged
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while another is in flight");

    // only an eligible thread is ever unlinked
    a_unlink_eligible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.unlink |-> stat.eligible)
        else $error("unlink of an ineligible thread");
`endif

endmodule

FILE: design/prq_ctrl.sv
// Sequencer for insert and pick requests.
// Depends on prq_pkg; drives t_cmd into prq_dp and reads t_stat back.
module prq_ctrl import prq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_INS_RD = 4'd2;
    localparam logic [3:0] S_INS_WR = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_HEAD   = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_UNLINK = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_pick) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else if (i_stat.ins_ok) begin
                    n_state = S_INS_RD;
                end else begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_REJECT;
                    n_state        = S_RESP;
                end
            end
            S_INS_RD: begin
                o_cmd.ins_rd = 1'b1;
                n_state      = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.ins_wr   = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = ST_DONE;
                n_state        = S_RESP;
            end
            S_SCAN: begin
                if (i_stat.mask_empty) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_NONE;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.scan_sel = 1'b1;
                    n_state        = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.walk_start = 1'b1;
                n_state          = S_WALK;
            end
            S_WALK: begin
                if (i_stat.eligible) begin
                    n_state = S_UNLINK;
                end else if (i_stat.next_null) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.walk_next = 1'b1;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink    = 1'b1;
                o_cmd.res_set   = 1'b1;
                o_cmd.res_code  = ST_DONE;
                o_cmd.res_found = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/prq_dp.sv
// Datapath: request registers, level and thread memories, bitmap, result register.
// Depends on prq_pkg; commanded by prq_ctrl.
module prq_dp import prq_pkg::*; #(
    parameter int NUM_LEVELS  = 64,
    parameter int MAX_THREADS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_type,
    input  logic [FIELD_W-1:0] i_thread_id,
    input  logic [FIELD_W-1:0] i_priority_req,
    input  logic               i_target_any,
    input  logic [CPU_W-1:0]   i_target_cpu,
    input  logic [CPU_W-1:0]   i_cpu_id,
    input  logic [FIELD_W-1:0] i_min_prio,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_status            o_status,
    output logic [FIELD_W-1:0] o_picked_thread,
    input  t_cmd               i_cmd,
    output t_stat              o_stat
);

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int SLOT_W = $clog2(MAX_THREADS);
    localparam int LINK_W = SLOT_W + 1;  // top bit marks a null link
    localparam int AFF_W  = CPU_W + 1;   // top bit is the any-CPU flag

    localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {SLOT_W{1'b0}}};

    // request registers
    logic              r_pick;
    logic              r_tid_ok;
    logic [SLOT_W-1:0] r_tid;
    logic [LVL_W-1:0]  r_lvl;
    logic [AFF_W-1:0]  r_aff;
    logic [CPU_W-1:0]  r_cpu;
    logic [LVL_W-1:0]  r_lim;

    // queue state
    logic [NUM_LEVELS-1:0]  r_bitmap;
    logic [MAX_THREADS-1:0] r_mark;
    logic [NUM_LEVELS-1:0]  r_mask;
    logic [LVL_W-1:0]       r_lvl_sel;
    logic [SLOT_W-1:0]      r_cur;

    // memories and their registered read data
    logic [LINK_W-1:0] head_mem [NUM_LEVELS];
    logic [LINK_W-1:0] tail_mem [NUM_LEVELS];
    logic [LINK_W-1:0] next_mem [MAX_THREADS];
    logic [LINK_W-1:0] prev_mem [MAX_THREADS];
    logic [AFF_W-1:0]  aff_mem  [MAX_THREADS];
    logic [LINK_W-1:0] r_head_rd;
    logic [LINK_W-1:0] r_tail_rd;
    logic [LINK_W-1:0] r_next_rd;
    logic [LINK_W-1:0] r_prev_rd;
    logic [AFF_W-1:0]  r_aff_rd;

    // result
    t_status            r_res_status;
    logic [FIELD_W-1:0] r_res_pick;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [FIELD_W-1:0] r_out_pick;

    logic [NUM_LEVELS-1:0] lim_mask;
    logic [NUM_LEVELS-1:0] lowest;
    logic [LVL_W-1:0]      sel_lvl;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  tail_live;
    logic                  pv_null;
    logic                  nx_null;

    assign tail_live = r_bitmap[r_lvl];
    assign pv_null   = r_prev_rd[SLOT_W];
    assign nx_null   = r_next_rd[SLOT_W];

    // lowest candidate level in the scan mask
    assign lowest = r_mask & (~r_mask + NUM_LEVELS'(1));

    always_comb begin
        lim_mask = '0;
        sel_lvl  = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lim_mask[i] = (i <= int'(r_lim));
            if (lowest[i]) sel_lvl = sel_lvl | LVL_W'(i);
        end
    end

    always_comb begin
        if (i_cmd.walk_start)     rd_addr = r_head_rd[SLOT_W-1:0];
        else if (i_cmd.walk_next) rd_addr = r_next_rd[SLOT_W-1:0];
        else                      rd_addr = r_cur;
    end

    // capture request, clamping level and limit
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pick   <= i_req_type;
            r_tid_ok <= (int'(i_thread_id) < MAX_THREADS);
            r_tid    <= SLOT_W'(i_thread_id);
            r_lvl    <= (int'(i_priority_req) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                             : LVL_W'(i_priority_req);
            r_lim    <= (int'(i_min_prio) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                         : LVL_W'(i_min_prio);
            r_aff    <= {i_target_any, i_target_cpu};
            r_cpu    <= i_cpu_id;
        end
        if (i_cmd.scan_init) r_mask <= r_bitmap & lim_mask;
        else if (i_cmd.scan_sel) r_mask <= r_mask & ~lowest;
        if (i_cmd.scan_sel) r_lvl_sel <= sel_lvl;
        if (i_cmd.walk_start || i_cmd.walk_next) r_cur <= rd_addr;
    end

    // level memories
    always_ff @(posedge i_clk) begin
        r_head_rd <= head_mem[sel_lvl];
        r_tail_rd <= tail_mem[r_lvl];
        if (i_cmd.ins_wr && !tail_live) head_mem[r_lvl] <= {1'b0, r_tid};
        else if (i_cmd.unlink && pv_null) head_mem[r_lvl_sel] <= r_next_rd;
        if (i_cmd.ins_wr) tail_mem[r_lvl] <= {1'b0, r_tid};
        else if (i_cmd.unlink && nx_null) tail_mem[r_lvl_sel] <= r_prev_rd;
    end

    // thread memories
    always_ff @(posedge i_clk) begin
        r_next_rd <= next_mem[rd_addr];
        r_prev_rd <= prev_mem[rd_addr];
        r_aff_rd  <= aff_mem[rd_addr];
        if (i_cmd.ins_rd) next_mem[r_tid] <= NULL_LINK;
        else if (i_cmd.ins_wr && tail_live) next_mem[r_tail_rd[SLOT_W-1:0]] <= {1'b0, r_tid};
        else if (i_cmd.unlink && !pv_null) next_mem[r_prev_rd[SLOT_W-1:0]] <= r_next_rd;
        if (i_cmd.ins_wr) prev_mem[r_tid] <= tail_live ? r_tail_rd : NULL_LINK;
        else if (i_cmd.unlink && !nx_null) prev_mem[r_next_rd[SLOT_W-1:0]] <= r_prev_rd;
        if (i_cmd.ins_wr) aff_mem[r_tid] <= r_aff;
    end

    // bitmap, queued marks, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap    <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_wr) begin
                r_bitmap[r_lvl] <= 1'b1;
                r_mark[r_tid]   <= 1'b1;
            end
            if (i_cmd.unlink) begin
                r_mark[r_cur] <= 1'b0;
                if (pv_null && nx_null) r_bitmap[r_lvl_sel] <= 1'b0;
            end
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_pick   <= i_cmd.res_found ? FIELD_W'(r_cur) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_pick   <= r_res_pick;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_picked_thread = r_out_pick;

    assign o_stat.is_pick    = r_pick;
    assign o_stat.ins_ok     = r_tid_ok && !r_mark[r_tid];
    assign o_stat.mask_empty = (r_mask == '0);
    assign o_stat.eligible   = r_aff_rd[CPU_W] || (r_aff_rd[CPU_W-1:0] == r_cpu);
    assign o_stat.next_null  = nx_null;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.bitmap_any = |r_bitmap;
    assign o_stat.marks_any  = |r_mark;

endmodule

FILE: dv/prq_checker.sv
// Checker for the priority run queue: predicts each result from the accepted requests
// and compares it with what the block returns. Depends on prq_pkg.
module prq_checker import prq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic               i_req_type,
    input  logic [FIELD_W-1:0] i_thread_id,
    input  logic [FIELD_W-1:0] i_priority_req,
    input  logic               i_target_any,
    input  logic [CPU_W-1:0]   i_target_cpu,
    input  logic [CPU_W-1:0]   i_cpu_id,
    input  logic [FIELD_W-1:0] i_min_prio,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  t_status            i_status,
    input  logic [FIELD_W-1:0] i_picked_thread,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS = 64;
    localparam int SLOTS  = 64;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] picked;
    } t_answer;

    // FIFO order per level kept as queues of slots
    int        level_list [LEVELS][$];
    logic      slot_any   [SLOTS];
    logic [3:0] slot_cpu  [SLOTS];
    logic      slot_queued[SLOTS];
    t_answer   answers_due[$];

    function automatic t_answer run_queue_step(logic req, logic [5:0] tid, logic [5:0] lvl,
                                               logic any, logic [3:0] tcpu,
                                               logic [3:0] cpu, logic [5:0] lim);
        t_answer a;
        a.status = ST_NONE;
        a.picked = '0;
        if (req == 1'b0) begin
            if (slot_queued[tid]) begin
                a.status = ST_REJECT;
            end else begin
                slot_queued[tid] = 1'b1;
                slot_any[tid] = any;
                slot_cpu[tid] = tcpu;
                level_list[lvl].push_back(tid);
                a.status = ST_DONE;
            end
        end else begin
            for (int l = 0; l <= lim; l++) begin
                for (int k = 0; k < level_list[l].size(); k++) begin
                    int s;
                    s = level_list[l][k];
                    if (slot_any[s] || slot_cpu[s] == cpu) begin
                        level_list[l].delete(k);
                        slot_queued[s] = 1'b0;
                        a.status = ST_DONE;
                        a.picked = s[5:0];
                        return a;
                    end
                end
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer due;
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) level_list[l].delete();
            for (int s = 0; s < SLOTS; s++) slot_queued[s] = 1'b0;
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            // compare results first, then predict from the request of this edge
            if (i_res_valid && i_res_ready) begin
                if (answers_due.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result status=%0d picked=%0d",
                                 i_status, i_picked_thread);
                end else begin
                    due = answers_due.pop_front();
                    if (due.status !== i_status || due.picked !== i_picked_thread) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected status=%0d picked=%0d, got %0d %0d",
                                     due.status, due.picked, i_status, i_picked_thread);
                    end
                end
            end
            if (i_valid && i_ready_in)
                answers_due.push_back(run_queue_step(i_req_type, i_thread_id,
                    i_priority_req, i_target_any, i_target_cpu, i_cpu_id, i_min_prio));
        end
        o_pending <= answers_due.size();
    end
endmodule

FILE: dv/priority_run_queue_with_affinity_tb.sv
// Testbench top for the priority run queue: makes requests, idles both channels
// and gives the verdict. Depends on prq_pkg, prq_checker and the block itself.
module priority_run_queue_with_affinity_tb;
    import prq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1830;
    localparam int CYCLE_LIMIT     = 2000000;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_PICK   = 1'b1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_req_type = 1'b0;
    logic [FIELD_W-1:0] i_thread_id = '0;
    logic [FIELD_W-1:0] i_priority_req = '0;
    logic               i_target_any = 1'b0;
    logic [CPU_W-1:0]   i_target_cpu = '0;
    logic [CPU_W-1:0]   i_cpu_id = '0;
    logic [FIELD_W-1:0] i_min_prio = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    t_status            o_status;
    logic [FIELD_W-1:0] o_picked_thread;

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    bit  calm_phase = 1'b0;     // no idling near the end
    bit  hold_off = 1'b0;       // long stall of the result side
    bit  stimulus_done = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    priority_run_queue_with_affinity DUT (.*);

    prq_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready),
        .i_req_type, .i_thread_id, .i_priority_req, .i_target_any,
        .i_target_cpu, .i_cpu_id, .i_min_prio,
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_status(o_status), .i_picked_thread(o_picked_thread),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts, a long hold-off on request, none at the end.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 9);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until accepted; maybe leave a gap after.
    task automatic offer_request(logic req, logic [5:0] tid, logic [5:0] lvl, logic any,
                                 logic [3:0] tcpu, logic [3:0] cpu, logic [5:0] lim);
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_thread_id    <= tid;
        i_priority_req <= lvl;
        i_target_any   <= any;
        i_target_cpu   <= tcpu;
        i_cpu_id       <= cpu;
        i_min_prio     <= lim;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic insert_thread(logic [5:0] tid, logic [5:0] lvl, logic any,
                                 logic [3:0] tcpu);
        offer_request(REQ_INSERT, tid, lvl, any, tcpu, 4'($urandom), 6'($urandom));
    endtask

    task automatic pick_thread(logic [3:0] cpu, logic [5:0] lim);
        offer_request(REQ_PICK, 6'($urandom), 6'($urandom), 1'($urandom),
                      4'($urandom), cpu, lim);
    endtask

    initial begin
        int kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pick, extremes of fields, duplicate insert, affinity miss,
        // FIFO order within a level, level limit.
        pick_thread(4'd0, 6'd63);
        insert_thread(6'd0, 6'd0, 1'b1, 4'd0);
        insert_thread(6'd63, 6'd63, 1'b0, 4'd15);
        insert_thread(6'd63, 6'd5, 1'b1, 4'd3);          // already queued
        insert_thread(6'd21, 6'd42, 1'b0, 4'd10);
        insert_thread(6'd42, 6'd42, 1'b0, 4'd5);
        insert_thread(6'd7, 6'd42, 1'b1, 4'd0);
        pick_thread(4'd3, 6'd0);                         // takes slot 0
        pick_thread(4'd15, 6'd41);                       // nothing within the limit
        pick_thread(4'd5, 6'd63);                        // walks past a bound thread
        pick_thread(4'd9, 6'd63);                        // any-CPU thread
        pick_thread(4'd9, 6'd63);                        // no eligible thread left at 42
        pick_thread(4'd15, 6'd63);
        pick_thread(4'd10, 6'd63);
        pick_thread(4'd10, 6'd63);                       // empty again

        // Fill the block while the result side holds off.
        hold_off = 1'b1;
        for (int r = 0; r < RANDOM_REQUESTS; r++) begin
            if (r == RANDOM_REQUESTS - 200) calm_phase = 1'b1;
            kind = $urandom_range(0, 99);
            // mostly few levels and CPUs so that lists grow and walks happen
            if (kind < 50)
                insert_thread(6'($urandom), ($urandom_range(0, 3) == 0) ? 6'($urandom)
                              : 6'($urandom_range(0, 3)), 1'($urandom_range(0, 3) == 0),
                              ($urandom_range(0, 3) == 0) ? 4'($urandom)
                              : 4'($urandom_range(0, 2)));
            else
                pick_thread(($urandom_range(0, 3) == 0) ? 4'($urandom)
                            : 4'($urandom_range(0, 2)),
                            ($urandom_range(0, 1) == 0) ? 6'd63 : 6'($urandom));
        end
        i_valid <= 1'b0;
        stimulus_done = 1'b1;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
